FILE: hw/rtl/crps_pkg.sv
// ----------------------------------------------------------------------------
// crps_pkg
// Shared types and constants for the sparse PageRank step engine.
// ----------------------------------------------------------------------------
package crps_pkg;

    localparam int NODE_COUNT_W = 11;
    localparam int FRAC_W       = 32;
    localparam int SLOT_W       = 13;
    localparam int COC_W        = 14;
    localparam int FUNC_W       = 3;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 8192;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;
    localparam logic [FRAC_W-1:0]       DAMPING_RESET    = 32'd1825361101;
    localparam logic [FRAC_W-1:0]       ONE_Q31          = 32'h8000_0000;

    // Function codes of an input beat.
    localparam logic [FUNC_W-1:0] FN_LOAD_ROW  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_EDGE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOAD_RANK = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RUN       = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ      = 3'd4;

    // Configuration register indexes.
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_DAMPING    = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [COC_W-1:0]  count_or_column;
        logic [FRAC_W-1:0] fraction;
    } in_item_t;

    typedef struct packed {
        logic [FRAC_W-1:0] value;
        logic              is_norm;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_ROW0,
        ST_ROWA,
        ST_ROW,
        ST_ROWW,
        ST_EDGE,
        ST_MUL,
        ST_ADD,
        ST_NORM,
        ST_SQRT
    } state_t;

endpackage

FILE: hw/rtl/csr_pagerank_step_top.sv
// ----------------------------------------------------------------------------
// csr_pagerank_step_top
// One PageRank power-iteration step over a CSR sparse matrix, fixed point.
// ----------------------------------------------------------------------------
// Usage. Input beats arrive on s_valid/s_ready with an in_item_t payload.
// Function 0 writes a row start offset, function 1 writes an edge (column
// and Q1.31 weight), function 2 writes an old rank entry. These beats give
// no result and are taken one per cycle while the engine is idle.
// Function 4 reads one new rank; its result beat goes through the READ state
// and the output register to m_valid, and the engine then returns to idle.
// Function 3 runs the step: the divider forms the teleport term, then the
// row pass, the norm pass and the square root follow, and the result beat
// goes through the output register to m_valid. The single read port of
// each memory, one edge per cycle, sets the edge phase. The result beat
// carries the Q8.24 difference norm with is_norm set.
// Reset (aresetn low at a clock edge) returns the sequencer to idle, drops
// m_valid and restores node_count to 1024 and damping to 0.85. Memory
// contents are not cleared and must be loaded before use.
// A stalled receiver holds the result in the output register; load beats
// are still taken meanwhile, but run and read beats wait until it drains.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module csr_pagerank_step_top #(
    parameter int MAX_NODES = crps_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = crps_pkg::MAX_EDGES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  crps_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output crps_pkg::out_item_t         m_data,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [crps_pkg::FRAC_W-1:0] cfg_data
);

    logic [crps_pkg::NODE_COUNT_W-1:0] node_count_reg;
    logic [crps_pkg::FRAC_W-1:0]       damping_reg;
    logic                              m_valid_reg;
    crps_pkg::out_item_t               m_data_reg;
    logic                              busy;
    logic                              res_valid;
    crps_pkg::out_item_t               res_data;
    logic                              out_stalled;
    logic                              needs_out;
    logic                              in_fire;

    // Register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= crps_pkg::NODE_COUNT_RESET;
            damping_reg    <= crps_pkg::DAMPING_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                crps_pkg::REG_NODE_COUNT: node_count_reg <= cfg_data[crps_pkg::NODE_COUNT_W-1:0];
                crps_pkg::REG_DAMPING:    damping_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A beat that produces a result is only taken once the output register
    // is free or is being emptied this cycle, so the engine never overruns it.
    assign out_stalled = m_valid_reg && !m_ready;
    assign needs_out   = (s_data.func == crps_pkg::FN_RUN) || (s_data.func == crps_pkg::FN_READ);
    assign s_ready     = !busy && !(needs_out && out_stalled);
    assign in_fire     = s_valid && s_ready;

    crps_engine #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .node_count (node_count_reg),
        .damping    (damping_reg),
        .in_fire    (in_fire),
        .in_data    (s_data),
        .busy       (busy),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/crps_div.sv
// ----------------------------------------------------------------------------
// crps_div
// Restoring divider, one quotient bit per cycle, for the teleport term.
// ----------------------------------------------------------------------------
module crps_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [crps_pkg::FRAC_W-1:0]         dividend,
    input  logic [crps_pkg::NODE_COUNT_W-1:0]   divisor,
    output logic                                done,
    output logic [crps_pkg::FRAC_W-1:0]         quotient
);

    logic [crps_pkg::FRAC_W-1:0]       dvd_reg;
    logic [crps_pkg::FRAC_W-1:0]       q_reg;
    logic [crps_pkg::NODE_COUNT_W:0]   rem_reg;
    logic [crps_pkg::NODE_COUNT_W-1:0] dvs_reg;
    logic [4:0]                        cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [crps_pkg::NODE_COUNT_W:0]   rem_sh;
    logic                              ge;

    always_comb begin
        rem_sh = {rem_reg[crps_pkg::NODE_COUNT_W-1:0], dvd_reg[crps_pkg::FRAC_W-1]};
        ge     = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[crps_pkg::FRAC_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            q_reg   <= {q_reg[crps_pkg::FRAC_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: hw/rtl/crps_isqrt.sv
// ----------------------------------------------------------------------------
// crps_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module crps_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

FILE: hw/rtl/crps_engine.sv
// ----------------------------------------------------------------------------
// crps_engine
// Matrix and vector memories with the sequencer that walks rows, edges and
// the norm pass.
// ----------------------------------------------------------------------------
module crps_engine #(
    parameter int MAX_NODES = crps_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = crps_pkg::MAX_EDGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [crps_pkg::NODE_COUNT_W-1:0] node_count,
    input  logic [crps_pkg::FRAC_W-1:0]       damping,
    input  logic                              in_fire,
    input  crps_pkg::in_item_t                in_data,
    output logic                              busy,
    output logic                              res_valid,
    output crps_pkg::out_item_t               res_data
);

    localparam int RAW  = $clog2(MAX_NODES);
    localparam int RSAW = $clog2(MAX_NODES + 1);
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int JW   = (EAW + 1 > crps_pkg::COC_W) ? EAW + 1 : crps_pkg::COC_W;
    localparam int IW   = crps_pkg::NODE_COUNT_W + 1;
    localparam int CW   = crps_pkg::COC_W;
    localparam int FW   = crps_pkg::FRAC_W;

    crps_pkg::state_t state_reg, state_next;

    logic [CW-1:0] rs_mem   [MAX_NODES+1];
    logic [CW-1:0] col_mem  [MAX_EDGES];
    logic [FW-1:0] wt_mem   [MAX_EDGES];
    logic [FW-1:0] rin_mem  [MAX_NODES];
    logic [FW-1:0] rout_mem [MAX_NODES];

    logic [CW-1:0] rs_q, col_q;
    logic [FW-1:0] wt_q, rin_q, rout_q;

    logic [RSAW-1:0] rs_addr;
    logic [EAW-1:0]  edge_addr;
    logic [RAW-1:0]  rin_addr, rout_addr;

    logic [31:0] slot32, i32, ip1, col32, rs32;
    logic        wr_rs, wr_edge, wr_rin;

    logic [crps_pkg::NODE_COUNT_W-1:0] n_eff, n_reg;
    logic [FW-1:0]  d_eff, d_reg, teleport_reg;
    logic [IW-1:0]  i_reg;
    logic [CW-1:0]  start_reg, end_raw_reg;
    logic [JW-1:0]  j_reg, end_reg;
    logic           slot_ok_reg;

    logic           e_v_reg, r_v_reg, p_v_reg;
    logic [FW-1:0]  wt_d_reg;
    logic [32:0]    prod_reg;
    logic [35:0]    acc_reg, acc_add;
    logic [FW-1:0]  acc_sat;
    logic [63:0]    mul_reg, wr_full;
    logic [33:0]    rank_sum;
    logic [FW-1:0]  new_rank;

    logic           n_v1_reg, n_v2_reg, n_v3_reg;
    logic [FW-1:0]  diff_reg;
    logic [49:0]    sq_reg;
    logic [63:0]    sq_acc_reg, sq_full;
    logic [64:0]    sq_add;

    logic edge_issue, norm_issue, last_node, col_ok;
    logic div_start, div_done, sqrt_start, sqrt_done;
    logic [FW-1:0] div_q;
    logic [31:0]   sqrt_root;

    // ---- decode and effective configuration ----
    always_comb begin
        slot32  = 32'(in_data.slot);
        wr_rs   = in_fire && (in_data.func == crps_pkg::FN_LOAD_ROW) && (slot32 <= MAX_NODES);
        wr_edge = in_fire && (in_data.func == crps_pkg::FN_LOAD_EDGE) && (slot32 < MAX_EDGES);
        wr_rin  = in_fire && (in_data.func == crps_pkg::FN_LOAD_RANK) && (slot32 < MAX_NODES);
        div_start = in_fire && (in_data.func == crps_pkg::FN_RUN) && (state_reg == crps_pkg::ST_IDLE);

        if (node_count == '0) begin
            n_eff = crps_pkg::NODE_COUNT_W'(1);
        end else if (32'(node_count) > MAX_NODES) begin
            n_eff = crps_pkg::NODE_COUNT_W'(MAX_NODES);
        end else begin
            n_eff = node_count;
        end
        d_eff = (damping > crps_pkg::ONE_Q31) ? crps_pkg::ONE_Q31 : damping;

        i32   = 32'(i_reg);
        ip1   = i32 + 32'd1;
        col32 = 32'(col_q);
        rs32  = 32'(rs_q);
        col_ok = col32 < MAX_NODES;

        rs_addr   = (state_reg == crps_pkg::ST_ROW0) ? '0 : ip1[RSAW-1:0];
        edge_addr = j_reg[EAW-1:0];
        rin_addr  = (state_reg == crps_pkg::ST_NORM) ? i32[RAW-1:0] : col32[RAW-1:0];
        rout_addr = (state_reg == crps_pkg::ST_NORM) ? i32[RAW-1:0] : slot32[RAW-1:0];

        edge_issue = (state_reg == crps_pkg::ST_EDGE) && (j_reg < end_reg);
        norm_issue = (state_reg == crps_pkg::ST_NORM) && (i_reg < {1'b0, n_reg});
        last_node  = (i_reg + IW'(1)) == {1'b0, n_reg};

        acc_add  = acc_reg + 36'(prod_reg);
        acc_sat  = (acc_reg[35:32] != '0) ? '1 : acc_reg[31:0];
        wr_full  = 64'(wt_d_reg) * 64'(rin_q);
        rank_sum = {1'b0, mul_reg[63:31]} + {2'b0, teleport_reg};
        new_rank = (rank_sum[33:32] != '0) ? '1 : rank_sum[31:0];
        sq_full  = 64'(diff_reg) * 64'(diff_reg);
        sq_add   = {1'b0, sq_acc_reg} + 65'(sq_reg);
    end

    // ---- memories ----
    always_ff @(posedge aclk) begin
        if (wr_rs) begin
            rs_mem[slot32[RSAW-1:0]] <= in_data.count_or_column;
        end
        rs_q <= rs_mem[rs_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_edge) begin
            col_mem[slot32[EAW-1:0]] <= in_data.count_or_column;
            wt_mem[slot32[EAW-1:0]]  <= in_data.fraction;
        end
        col_q <= col_mem[edge_addr];
        wt_q  <= wt_mem[edge_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_rin) begin
            rin_mem[slot32[RAW-1:0]] <= in_data.fraction;
        end
        rin_q <= rin_mem[rin_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == crps_pkg::ST_ADD) begin
            rout_mem[i32[RAW-1:0]] <= new_rank;
        end
        rout_q <= rout_mem[rout_addr];
    end

    // ---- iterative units ----
    crps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (crps_pkg::ONE_Q31 - d_eff),
        .divisor  (n_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    crps_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_acc_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ---- sequencer ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        res_valid  = 1'b0;
        res_data   = '0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            crps_pkg::ST_IDLE: begin
                if (in_fire && in_data.func == crps_pkg::FN_RUN) begin
                    state_next = crps_pkg::ST_DIV;
                end else if (in_fire && in_data.func == crps_pkg::FN_READ) begin
                    state_next = crps_pkg::ST_READ;
                end
            end
            crps_pkg::ST_READ: begin
                res_valid        = 1'b1;
                res_data.value   = slot_ok_reg ? rout_q : '0;
                res_data.is_norm = 1'b0;
                state_next       = crps_pkg::ST_IDLE;
            end
            crps_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = crps_pkg::ST_ROW0;
                end
            end
            crps_pkg::ST_ROW0: state_next = crps_pkg::ST_ROWA;
            crps_pkg::ST_ROWA: state_next = crps_pkg::ST_ROW;
            crps_pkg::ST_ROW:  state_next = crps_pkg::ST_ROWW;
            crps_pkg::ST_ROWW: state_next = crps_pkg::ST_EDGE;
            crps_pkg::ST_EDGE: begin
                if (!edge_issue && !e_v_reg && !r_v_reg && !p_v_reg) begin
                    state_next = crps_pkg::ST_MUL;
                end
            end
            crps_pkg::ST_MUL: state_next = crps_pkg::ST_ADD;
            crps_pkg::ST_ADD: begin
                state_next = last_node ? crps_pkg::ST_NORM : crps_pkg::ST_ROW;
            end
            crps_pkg::ST_NORM: begin
                if (!norm_issue && !n_v1_reg && !n_v2_reg && !n_v3_reg) begin
                    sqrt_start = 1'b1;
                    state_next = crps_pkg::ST_SQRT;
                end
            end
            crps_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    res_valid        = 1'b1;
                    res_data.value   = sqrt_root;
                    res_data.is_norm = 1'b1;
                    state_next       = crps_pkg::ST_IDLE;
                end
            end
            default: state_next = crps_pkg::ST_IDLE;
        endcase
    end

    // ---- pipeline valids ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_v_reg  <= 1'b0;
            r_v_reg  <= 1'b0;
            p_v_reg  <= 1'b0;
            n_v1_reg <= 1'b0;
            n_v2_reg <= 1'b0;
            n_v3_reg <= 1'b0;
        end else begin
            e_v_reg  <= edge_issue;
            r_v_reg  <= e_v_reg && col_ok;
            p_v_reg  <= r_v_reg;
            n_v1_reg <= norm_issue;
            n_v2_reg <= n_v1_reg;
            n_v3_reg <= n_v2_reg;
        end
    end

    // ---- datapath ----
    always_ff @(posedge aclk) begin
        wt_d_reg <= wt_q;
        prod_reg <= wr_full[63:31];
        mul_reg  <= 64'(acc_sat) * 64'(d_reg);
        diff_reg <= (rout_q >= rin_q) ? rout_q - rin_q : rin_q - rout_q;
        sq_reg   <= sq_full[63:14];

        if (state_reg == crps_pkg::ST_ROWW) begin
            acc_reg <= '0;
        end else if (p_v_reg) begin
            acc_reg <= (acc_add[35:32] != '0) ? 36'h1_0000_0000 : acc_add;
        end

        if (div_start) begin
            sq_acc_reg <= '0;
        end else if (n_v3_reg) begin
            sq_acc_reg <= sq_add[64] ? '1 : sq_add[63:0];
        end

        case (state_reg)
            crps_pkg::ST_IDLE: begin
                slot_ok_reg <= slot32 < MAX_NODES;
                n_reg       <= n_eff;
                d_reg       <= d_eff;
                i_reg       <= '0;
            end
            crps_pkg::ST_DIV: begin
                teleport_reg <= div_q;
            end
            crps_pkg::ST_ROWA: begin
                start_reg <= rs_q;
            end
            crps_pkg::ST_ROWW: begin
                end_raw_reg <= rs_q;
                end_reg     <= (rs32 > MAX_EDGES) ? JW'(MAX_EDGES) : JW'(rs_q);
                j_reg       <= JW'(start_reg);
            end
            crps_pkg::ST_EDGE: begin
                if (edge_issue) begin
                    j_reg <= j_reg + JW'(1);
                end
            end
            crps_pkg::ST_ADD: begin
                start_reg <= end_raw_reg;
                i_reg     <= last_node ? '0 : i_reg + IW'(1);
            end
            crps_pkg::ST_NORM: begin
                if (norm_issue) begin
                    i_reg <= i_reg + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign busy = state_reg != crps_pkg::ST_IDLE;

endmodule

FILE: hw/rtl/crps_checker.sv
// ----------------------------------------------------------------------------
// crps_checker
// Port-level assertions for csr_pagerank_step_top.
// ----------------------------------------------------------------------------
module crps_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input crps_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input crps_pkg::out_item_t m_data
);

    logic run_fire, read_fire;

    assign run_fire  = s_valid && s_ready && (s_data.func == crps_pkg::FN_RUN);
    assign read_fire = s_valid && s_ready && (s_data.func == crps_pkg::FN_READ);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        run_fire |=> !s_ready && !m_valid)
        else $error("run beat did not occupy the engine");

    a_read_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        read_fire |=> ##1 m_valid && !m_data.is_norm)
        else $error("read result missing");

endmodule

bind csr_pagerank_step_top crps_checker u_crps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/sv/csr_pagerank_step_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_pagerank_step_top_tb
// Self-checking bench for the sparse PageRank step engine.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the corner cases first. Random
// phases then load a well-formed CSR graph, run one step and read back new
// ranks. Every accepted beat goes through an in-bench predictor, and result
// beats are checked in order against the predictor or a hand-typed value.
// ----------------------------------------------------------------------------
module csr_pagerank_step_top_tb;

    typedef crps_pkg::in_item_t  in_item_t;
    typedef crps_pkg::out_item_t out_item_t;

    localparam logic [2:0]   FN_LOAD_ROW      = crps_pkg::FN_LOAD_ROW;
    localparam logic [2:0]   FN_LOAD_EDGE     = crps_pkg::FN_LOAD_EDGE;
    localparam logic [2:0]   FN_LOAD_RANK     = crps_pkg::FN_LOAD_RANK;
    localparam logic [2:0]   FN_RUN           = crps_pkg::FN_RUN;
    localparam logic [2:0]   FN_READ          = crps_pkg::FN_READ;
    localparam logic         REG_NODE_COUNT   = crps_pkg::REG_NODE_COUNT;
    localparam logic         REG_DAMPING      = crps_pkg::REG_DAMPING;
    localparam logic [31:0]  ONE_Q31          = crps_pkg::ONE_Q31;
    localparam logic [31:0]  DAMPING_RESET    = crps_pkg::DAMPING_RESET;
    localparam logic [10:0]  NODE_COUNT_RESET = crps_pkg::NODE_COUNT_RESET;

    localparam int           NODES      = crps_pkg::MAX_NODES_DEF;
    localparam int           EDGES      = crps_pkg::MAX_EDGES_DEF;
    localparam int           CYCLE_CAP  = 1_000_000;
    localparam int           RANDOM_BEATS = 1150;
    // Cycles left after the last result before the engine counts as idle.
    localparam int           SETTLE     = 6;
    // Function codes the engine must ignore.
    localparam logic [2:0]   FN_RSVD_LO = FN_READ + 3'd1;
    localparam logic [2:0]   FN_RSVD_HI = 3'd7;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_index = REG_NODE_COUNT;
    logic [31:0] cfg_data = '0;

    csr_pagerank_step_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // One row of the directed table: either a register write or a beat,
    // optionally with a result value that is typed in by hand.
    typedef struct {
        bit        is_cfg;
        logic      reg_idx;
        logic [31:0] reg_val;
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    // A beat that has been driven, waiting to be accepted.
    typedef struct {
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } sent_beat_t;

    // Predictor state: the CSR tables, both rank vectors and the registers.
    logic [13:0] row_start_mem [0:NODES];
    logic [13:0] edge_col_mem  [0:EDGES-1];
    logic [31:0] edge_wt_mem   [0:EDGES-1];
    logic [31:0] old_rank      [0:NODES-1];
    logic [31:0] new_rank      [0:NODES-1];
    logic [10:0] node_cfg;
    logic [31:0] damp_cfg;

    // Which new-rank entries hold a value, so that reads never hit garbage.
    bit          rank_ready [0:NODES-1];

    sent_beat_t  in_flight [$];
    out_item_t   results_due [$];
    bit          failed;
    int          cycles;
    int          beats_sent;
    int          burst_left;
    int          rx_run;
    bit          rx_hold;
    dir_row_t    dir_tab [$];

    function automatic in_item_t mk_beat(logic [2:0] fn, int unsigned sl, int unsigned cc,
                                         logic [31:0] fr);
        in_item_t it;
        it.func            = fn;
        it.slot            = sl[12:0];
        it.count_or_column = cc[13:0];
        it.fraction        = fr;
        return it;
    endfunction

    function automatic dir_row_t beat_row(in_item_t it, bit typed, logic [31:0] val,
                                          logic nrm);
        dir_row_t r;
        r        = '{default: '0};
        r.beat   = it;
        r.typed  = typed;
        r.want.value   = val;
        r.want.is_norm = nrm;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic idx, logic [31:0] val);
        dir_row_t r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [31:0] floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    // One power-iteration step over the predictor's tables; returns the
    // Q8.24 norm of the change and leaves the new vector in new_rank.
    function automatic logic [31:0] pagerank_step();
        int unsigned     n;
        longint unsigned d;
        longint unsigned tele;
        longint unsigned sum;
        longint unsigned r;
        longint unsigned diff;
        longint unsigned sq;
        longint unsigned acc;
        longint unsigned stop;
        n = node_cfg;
        if (n == 0) n = 1;
        if (n > NODES) n = NODES;
        d    = (damp_cfg > ONE_Q31) ? ONE_Q31 : damp_cfg;
        tele = (64'(ONE_Q31) - d) / n;
        for (int unsigned i = 0; i < n; i++) begin
            sum  = 0;
            stop = row_start_mem[i+1];
            if (stop > EDGES) stop = EDGES;
            for (longint unsigned j = row_start_mem[i]; j < stop; j++) begin
                if (edge_col_mem[j] < NODES)
                    sum += (64'(edge_wt_mem[j]) * 64'(old_rank[edge_col_mem[j][9:0]])) >> 31;
            end
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            r = ((sum * d) >> 31) + tele;
            if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
            new_rank[i] = r[31:0];
        end
        acc = 0;
        for (int unsigned i = 0; i < n; i++) begin
            diff = (new_rank[i] >= old_rank[i]) ? 64'(new_rank[i] - old_rank[i])
                                                : 64'(old_rank[i] - new_rank[i]);
            sq = (diff * diff) >> 14;
            if (acc > ~64'd0 - sq) acc = ~64'd0;
            else acc += sq;
        end
        return floor_sqrt(acc);
    endfunction

    // Applies one accepted beat to the predictor; returns 1 when it yields
    // a result beat.
    function automatic bit apply_beat(in_item_t it, output out_item_t res);
        res = '0;
        case (it.func)
            FN_LOAD_ROW: begin
                if (it.slot <= NODES) row_start_mem[it.slot] = it.count_or_column;
                return 1'b0;
            end
            FN_LOAD_EDGE: begin
                edge_col_mem[it.slot] = it.count_or_column;
                edge_wt_mem[it.slot]  = it.fraction;
                return 1'b0;
            end
            FN_LOAD_RANK: begin
                if (it.slot < NODES) old_rank[it.slot] = it.fraction;
                return 1'b0;
            end
            FN_RUN: begin
                res.value   = pagerank_step();
                res.is_norm = 1'b1;
                return 1'b1;
            end
            FN_READ: begin
                res.value   = (it.slot < NODES) ? new_rank[it.slot] : 32'd0;
                res.is_norm = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Monitor: feeds accepted beats and register writes to the predictor and
    // checks every result beat against the oldest expectation.
    always @(posedge aclk) begin
        sent_beat_t sb;
        out_item_t  res;
        out_item_t  want;
        if (!aresetn) begin
            node_cfg = NODE_COUNT_RESET;
            damp_cfg = DAMPING_RESET;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_NODE_COUNT) node_cfg = cfg_data[10:0];
                else damp_cfg = cfg_data;
            end
            if (s_valid && s_ready) begin
                sb = in_flight.pop_front();
                if (apply_beat(sb.beat, res))
                    results_due.push_back(sb.typed ? sb.want : res);
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected: value %h is_norm %b",
                           m_data.value, m_data.is_norm);
                    failed = 1'b1;
                end else begin
                    want = results_due.pop_front();
                    if (m_data.value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, m_data.value);
                        failed = 1'b1;
                    end
                    if (m_data.is_norm !== want.is_norm) begin
                        $error("is_norm: expected %b, got %b", want.is_norm, m_data.is_norm);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Receiver stalls on its own pattern: short stalls between ready runs of
    // varying length, some of them long enough to count as no stalling.
    always @(negedge aclk) begin
        if (rx_run == 0) begin
            rx_hold = ($urandom_range(0, 2) == 0);
            rx_run  = rx_hold ? $urandom_range(1, 12) : $urandom_range(1, 60);
        end
        rx_run--;
        m_ready <= !rx_hold;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL csr_pagerank_step_top");
            $finish;
        end
    end

    // Drives one beat in the sender's burst pattern and holds it until it is
    // accepted. Called and returns at a falling edge.
    task automatic send_beat(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
        sent_beat_t sb;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        sb.beat  = it;
        sb.typed = typed;
        sb.want  = want;
        in_flight.push_back(sb);
        s_valid <= 1'b1;
        s_data  <= it;
        if (it.func <= FN_READ) beats_sent++;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Holds the sender until every expected result has come back and the
    // engine has had time to settle.
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (results_due.size() != 0 || in_flight.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // One random phase: set the registers, load a well-formed CSR graph with
    // some noise shuffled in, run the step and read back new ranks.
    task automatic random_phase(bit big);
        int unsigned nc;
        int unsigned n;
        int unsigned offs [0:NODES];
        int unsigned top;
        int unsigned base;
        int unsigned p;
        int unsigned col;
        logic [31:0] dv;
        in_item_t    loads [$];
        in_item_t    it;

        if (big) nc = ($urandom_range(0, 1) == 0) ? NODES : $urandom_range(NODES + 1, 2047);
        else     nc = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
        n = (nc == 0) ? 1 : ((nc > NODES) ? NODES : nc);
        write_reg(REG_NODE_COUNT, nc);
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 4))
                0:       dv = 32'd0;
                1:       dv = ONE_Q31;
                2:       dv = DAMPING_RESET;
                default: dv = $urandom_range(0, ONE_Q31);
            endcase
            write_reg(REG_DAMPING, dv);
        end

        // Row offsets relative to the first edge; now and then a row start is
        // pushed forward, which makes that row empty (inverted) once it passes its end.
        p   = 0;
        top = 0;
        for (int unsigned i = 0; i < n; i++) begin
            offs[i] = p;
            if (!big && $urandom_range(0, 9) == 0) offs[i] = p + $urandom_range(1, 3);
            if (offs[i] > top) top = offs[i];
            if (big) p += ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
            else     p += $urandom_range(0, 4);
        end
        offs[n] = p;
        if (p > top) top = p;
        // Sometimes the graph ends right at the top of the edge table.
        base = ($urandom_range(0, 7) == 0) ? EDGES - top : $urandom_range(0, EDGES - top);

        for (int unsigned i = 0; i <= n; i++)
            loads.push_back(mk_beat(FN_LOAD_ROW, i, base + offs[i], '0));
        for (int unsigned j = base; j < base + top; j++) begin
            col = ($urandom_range(0, 6) == 0) ? $urandom_range(NODES, EDGES)
                                              : $urandom_range(0, n - 1);
            dv  = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, ONE_Q31);
            loads.push_back(mk_beat(FN_LOAD_EDGE, j, col, dv));
        end
        for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       dv = 32'd0;
                1:       dv = 32'hFFFF_FFFF;
                default: dv = $urandom_range(0, ONE_Q31);
            endcase
            loads.push_back(mk_beat(FN_LOAD_RANK, i, $urandom_range(0, 16383), dv));
        end
        // Noise: out-of-range loads, ignored codes and reads of old results.
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
                0: it = mk_beat(FN_LOAD_ROW, $urandom_range(NODES + 1, 8191),
                                $urandom_range(0, 16383), $urandom());
                1: it = mk_beat(FN_LOAD_RANK, $urandom_range(NODES, 8191),
                                $urandom_range(0, 16383), $urandom());
                2: it = mk_beat(3'($urandom_range(FN_RSVD_LO, FN_RSVD_HI)),
                                $urandom_range(0, 8191), $urandom_range(0, 16383),
                                $urandom());
                default: begin
                    p  = $urandom_range(0, NODES - 1);
                    it = rank_ready[p] ? mk_beat(FN_READ, p, 0, '0)
                                       : mk_beat(FN_READ, $urandom_range(NODES, 8191),
                                                 $urandom_range(0, 16383), $urandom());
                end
            endcase
            loads.push_back(it);
        end
        loads.shuffle();
        foreach (loads[k]) send_beat(loads[k]);

        send_beat(mk_beat(FN_RUN, $urandom_range(0, 8191), $urandom_range(0, 16383),
                          $urandom()));
        for (int unsigned i = 0; i < n; i++) rank_ready[i] = 1'b1;
        repeat ($urandom_range(1, 6)) begin
            p = ($urandom_range(0, 7) == 0) ? $urandom_range(NODES, 8191)
                                            : $urandom_range(0, n - 1);
            send_beat(mk_beat(FN_READ, p, $urandom_range(0, 16383), $urandom()));
        end
    endtask

    initial begin
        // Directed table. node_count 0 counts as one node, so row 0 and
        // row 1 offsets bound the only row.
        dir_tab.push_back(cfg_row(REG_NODE_COUNT, 32'd0));
        dir_tab.push_back(cfg_row(REG_DAMPING, ONE_Q31));
        // Ignored codes, then reads past the vector return zero.
        dir_tab.push_back(beat_row(mk_beat(FN_RSVD_LO, 8191, 16383, 32'hFFFF_FFFF), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_RSVD_HI, 0, 0, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_READ, NODES, 0, 0), 1, 32'd0, 1'b0));
        dir_tab.push_back(beat_row(mk_beat(FN_READ, 8191, 16383, 32'hFFFF_FFFF), 1, 32'd0, 1'b0));
        // One edge of weight 1.0, one whose column lies beyond the vector.
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_ROW, 0, 0, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_ROW, 1, 2, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_EDGE, 0, 0, ONE_Q31), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_EDGE, 1, EDGES, 32'hFFFF_FFFF), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_RANK, 0, 0, 32'h4000_0000), 0, 0, 0));
        // Out-of-range loads must leave the tables alone.
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_ROW, NODES + 1, 7, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_RANK, NODES, 0, 32'd1), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_RUN, 0, 0, 0), 1, 32'd0, 1'b1));
        dir_tab.push_back(beat_row(mk_beat(FN_READ, 0, 0, 0), 1, 32'h4000_0000, 1'b0));
        // Zero damping leaves only the teleport term, here a full 1.0.
        dir_tab.push_back(cfg_row(REG_DAMPING, 32'd0));
        dir_tab.push_back(beat_row(mk_beat(FN_RUN, 0, 0, 0), 1, 32'h0080_0000, 1'b1));
        dir_tab.push_back(beat_row(mk_beat(FN_READ, 0, 0, 0), 1, 32'h8000_0000, 1'b0));
        // Maximum weight times maximum rank saturates the row sum.
        dir_tab.push_back(cfg_row(REG_DAMPING, ONE_Q31));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_RANK, 0, 0, 32'hFFFF_FFFF), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_EDGE, 0, 0, 32'hFFFF_FFFF), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_RUN, 0, 0, 0), 1, 32'd0, 1'b1));
        dir_tab.push_back(beat_row(mk_beat(FN_READ, 0, 0, 0), 1, 32'hFFFF_FFFF, 1'b0));
        // A row that ends at the very top of the edge table.
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_ROW, 0, EDGES - 2, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_ROW, 1, EDGES, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_EDGE, EDGES - 2, 0, 32'h4000_0000), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_EDGE, EDGES - 1, 0, 32'h1234_5678), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_RUN, 0, 0, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_READ, 0, 0, 0), 0, 0, 0));
        // An inverted row adds nothing, and the teleport term is zero here.
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_ROW, 0, 3, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_LOAD_ROW, 1, 1, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_RUN, 0, 0, 0), 0, 0, 0));
        dir_tab.push_back(beat_row(mk_beat(FN_READ, 0, 0, 0), 1, 32'd0, 1'b0));

        // Synchronous reset, held low from the start, then released once.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
            else send_beat(dir_tab[k].beat, dir_tab[k].typed, dir_tab[k].want);
        end
        rank_ready[0] = 1'b1;

        // Many small graphs until the beat budget is used up.
        while (beats_sent < RANDOM_BEATS) random_phase(1'b0);

        drain();
        repeat (40) @(negedge aclk);
        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("PASS csr_pagerank_step_top");
        end else begin
            $display("FAIL csr_pagerank_step_top");
        end
        $finish;
    end

endmodule
